@@ hw/rtl/frq_pkg.sv @@
// frq_pkg: codes and types shared by the frame ring queue files
// no dependencies
package frq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } frq_action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_ROOM  = 2'd3
    } frq_status_t;

    typedef enum logic [1:0] {
        REG_RING_DEPTH    = 2'd0,
        REG_MAX_FRAME_LEN = 2'd1,
        REG_DROP_POLICY   = 2'd2,
        REG_UNUSED        = 2'd3
    } frq_reg_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SEND = 2'd2
    } frq_state_t;

    localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;

endpackage

@@ hw/rtl/frq_if.sv @@
// frq_if: request, result and configuration channels of the frame ring queue
// depends on frq_pkg
interface frq_req_if;
    import frq_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data;
    logic       last;
    logic [6:0] out_room;
    modport source (output valid, action, data, last, out_room, input ready);
    modport sink   (input valid, action, data, last, out_room, output ready);
endinterface

interface frq_rsp_if;
    import frq_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  byte_out;
    logic        end_of_run;
    logic        frame_dropped;
    logic [3:0]  frames_queued;
    logic [31:0] dropped_total;
    modport source (output valid, status, byte_out, end_of_run, frame_dropped,
                    frames_queued, dropped_total, input ready);
    modport sink   (input valid, status, byte_out, end_of_run, frame_dropped,
                    frames_queued, dropped_total, output ready);
endinterface

interface frq_cfg_if;
    import frq_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

@@ hw/rtl/frq_ram.sv @@
// frq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module frq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 576
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hw/rtl/frame_ring_queue_with_drop_policy.sv @@
// frame_ring_queue_with_drop_policy: ring of variable-length byte frames
// depends on frq_pkg, frq_if (channels) and frq_ram (frame byte store)
//
// usage: requests enter on req, results leave on rsp, registers are written on cfg.
// a push request carries one frame byte; only its last byte gives a result
// (ok or too long), and a full ring either frees the oldest frame or drops the
// incoming one, per the drop policy register. a pop gives one result per frame
// byte, or a single empty / room-too-small result. a status query gives one ok result.
// a single result is loaded into the output register when its request is taken.
// a pop streams its bytes, each read from the byte ram in S_READ and then loaded
// into the output register in S_SEND.
// throughput: one request a cycle for pushes and queries while rsp keeps up; a pop
// holds the request channel until its last byte is in the output register. when rsp
// stalls the output register holds its result and no new request is taken until it
// drains. cfg is always ready; the user must write it only while idle (not enforced).
// reset: ring empty, ring positions map to physical slots in order, the spare
// slot is the last one, drop counter zero, registers at 8 / 64 / 0.
module frame_ring_queue_with_drop_policy #(
    parameter int SLOTS       = 8,
    parameter int FRAME_BYTES = 64
) (
    input  logic clk,
    input  logic rst_n,
    frq_req_if.sink   req,
    frq_rsp_if.source rsp,
    frq_cfg_if.sink   cfg
);
    import frq_pkg::*;

    localparam int PHYS = SLOTS + 1;
    localparam int PW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int SW   = $clog2(PHYS);
    localparam int LW   = $clog2(FRAME_BYTES + 1);
    localparam int AW   = $clog2(PHYS * FRAME_BYTES);

    logic [3:0]    depth_reg;
    logic [6:0]    maxlen_reg;
    logic          dropnew_reg;
    logic [PW-1:0] rp_reg, rp_next;
    logic [FW-1:0] fh_reg, fh_next;
    logic [SW-1:0] stg_reg, stg_next;
    logic [LW-1:0] slen_reg, slen_next;
    logic          ovf_reg, ovf_next;
    logic [31:0]   drop_reg, drop_next;
    logic [SW-1:0] map_reg [SLOTS];
    logic [LW-1:0] len_mem [PHYS];
    frq_state_t    state_reg, state_next;
    logic [SW-1:0] phys_reg, phys_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] cnt_reg, cnt_next;

    logic          ov_reg, ov_next;
    logic [1:0]    os_reg, os_next;
    logic [7:0]    ob_reg, ob_next;
    logic          oe_reg, oe_next;
    logic          od_reg, od_next;
    logic [3:0]    oq_reg, oq_next;
    logic [31:0]   ot_reg, ot_next;

    logic          out_free, accept, cfg_wr;
    logic          map_we, len_we;
    logic [PW-1:0] map_waddr;
    logic [SW-1:0] map_wdata;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    logic [FW-1:0] d, fh_n;
    logic [PW-1:0] rp_n, rp_inc, wpos;
    logic [LW-1:0] emax, len1, n_head;
    logic          ovf1;
    logic [SW-1:0] freed, head;
    logic [7:0]    sum8;

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    assign rsp.valid         = ov_reg;
    assign rsp.status        = os_reg;
    assign rsp.byte_out      = ob_reg;
    assign rsp.end_of_run    = oe_reg;
    assign rsp.frame_dropped = od_reg;
    assign rsp.frames_queued = oq_reg;
    assign rsp.dropped_total = ot_reg;

    frq_ram #(.WIDTH(8), .DEPTH(PHYS * FRAME_BYTES)) u_bytes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // normalized views of the ring state for this request
    always_comb
    begin
        if (depth_reg == 4'd0)
        begin
            d = FW'(1);
        end
        else if (8'(depth_reg) > 8'(SLOTS))
        begin
            d = FW'(SLOTS);
        end
        else
        begin
            d = FW'(depth_reg);
        end
        rp_n = (8'(rp_reg) >= 8'(d)) ? '0 : rp_reg;
        fh_n = (fh_reg > d) ? d : fh_reg;
        emax = (8'(maxlen_reg) > 8'(FRAME_BYTES)) ? LW'(FRAME_BYTES) : LW'(maxlen_reg);
        ovf1 = ovf_reg || (slen_reg >= emax);
        len1 = (slen_reg >= emax) ? slen_reg : slen_reg + LW'(1);
        rp_inc = (8'(rp_n) + 8'd1 == 8'(d)) ? '0 : PW'(8'(rp_n) + 8'd1);
        head = map_reg[rp_n];
        if (8'(head) >= 8'(PHYS))
        begin
            head = SW'(SLOTS);
        end
        n_head = (len_mem[head] > LW'(FRAME_BYTES)) ? LW'(FRAME_BYTES) : len_mem[head];
    end

    always_comb
    begin
        rp_next    = rp_reg;
        fh_next    = fh_reg;
        stg_next   = stg_reg;
        slen_next  = slen_reg;
        ovf_next   = ovf_reg;
        drop_next  = drop_reg;
        state_next = state_reg;
        phys_next  = phys_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !rsp.ready;
        os_next    = os_reg;
        ob_next    = ob_reg;
        oe_next    = oe_reg;
        od_next    = od_reg;
        oq_next    = oq_reg;
        ot_next    = ot_reg;
        map_we     = 1'b0;
        map_waddr  = '0;
        map_wdata  = stg_reg;
        len_we     = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = AW'(int'(stg_reg) * FRAME_BYTES + int'(slen_reg));
        ram_raddr  = AW'(int'(phys_reg) * FRAME_BYTES + int'(cnt_reg));
        wpos       = '0;
        freed      = '0;
        sum8       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rp_next = rp_n;
                    fh_next = fh_n;
                    os_next = ST_OK;
                    ob_next = 8'd0;
                    oe_next = 1'b1;
                    od_next = 1'b0;
                    case (frq_action_t'(req.action))
                        ACT_PUSH:
                        begin
                            ram_we    = (slen_reg < emax);
                            ovf_next  = ovf1;
                            slen_next = len1;
                            if (req.last)
                            begin
                                ov_next = 1'b1;
                                if (ovf1 || len1 == '0)
                                begin
                                    slen_next = '0;
                                    ovf_next  = 1'b0;
                                    os_next   = ST_TOO_LONG;
                                    oq_next   = 4'(fh_n);
                                    ot_next   = drop_reg;
                                end
                                else if (fh_n >= d && dropnew_reg)
                                begin
                                    drop_next = (drop_reg != DROP_MAX) ? drop_reg + 32'd1
                                                                       : drop_reg;
                                    slen_next = '0;
                                    od_next   = 1'b1;
                                    oq_next   = 4'(fh_n);
                                    ot_next   = drop_next;
                                end
                                else
                                begin
                                    // full with drop-oldest: free the head first
                                    if (fh_n >= d)
                                    begin
                                        drop_next = (drop_reg != DROP_MAX)
                                                  ? drop_reg + 32'd1 : drop_reg;
                                        od_next   = 1'b1;
                                        rp_next   = rp_inc;
                                        fh_next   = fh_n - FW'(1);
                                    end
                                    sum8 = 8'(rp_next) + 8'(fh_next);
                                    wpos = (sum8 >= 8'(d)) ? PW'(sum8 - 8'(d)) : PW'(sum8);
                                    len_we    = 1'b1;
                                    map_we    = 1'b1;
                                    map_waddr = wpos;
                                    freed     = map_reg[wpos];
                                    stg_next  = (8'(freed) < 8'(PHYS)) ? freed : SW'(SLOTS);
                                    fh_next   = fh_next + FW'(1);
                                    slen_next = '0;
                                    ovf_next  = 1'b0;
                                    oq_next   = 4'(fh_next);
                                    ot_next   = drop_next;
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            ov_next = 1'b1;
                            oq_next = 4'(fh_n);
                            ot_next = drop_reg;
                            if (fh_n == '0)
                            begin
                                os_next = ST_EMPTY;
                            end
                            else if (8'(req.out_room) < 8'(n_head))
                            begin
                                os_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                rp_next = rp_inc;
                                fh_next = fh_n - FW'(1);
                                oq_next = 4'(fh_n - FW'(1));
                                if (n_head != '0)
                                begin
                                    // bytes follow from the ram, one result each
                                    ov_next    = ov_reg && !rsp.ready;
                                    phys_next  = head;
                                    n_next     = n_head;
                                    cnt_next   = '0;
                                    state_next = S_READ;
                                end
                            end
                        end
                        ACT_QUERY:
                        begin
                            ov_next = 1'b1;
                            oq_next = 4'(fh_n);
                            ot_next = drop_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    os_next  = ST_OK;
                    ob_next  = ram_rdata;
                    oe_next  = (cnt_reg + LW'(1) == n_reg);
                    od_next  = 1'b0;
                    oq_next  = 4'(fh_reg);
                    ot_next  = drop_reg;
                    cnt_next = cnt_reg + LW'(1);
                    state_next = (cnt_reg + LW'(1) == n_reg) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writing the depth empties the ring
        if (cfg_wr && frq_reg_t'(cfg.index) == REG_RING_DEPTH)
        begin
            rp_next = '0;
            fh_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= 4'd8;
            maxlen_reg  <= 7'd64;
            dropnew_reg <= 1'b0;
            rp_reg      <= '0;
            fh_reg      <= '0;
            stg_reg     <= SW'(SLOTS);
            slen_reg    <= '0;
            ovf_reg     <= 1'b0;
            drop_reg    <= '0;
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                map_reg[i] <= SW'(i);
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (frq_reg_t'(cfg.index))
                    REG_RING_DEPTH:    depth_reg   <= cfg.wdata[3:0];
                    REG_MAX_FRAME_LEN: maxlen_reg  <= cfg.wdata;
                    REG_DROP_POLICY:   dropnew_reg <= cfg.wdata[0];
                    default:
                    begin
                    end
                endcase
            end
            rp_reg    <= rp_next;
            fh_reg    <= fh_next;
            stg_reg   <= stg_next;
            slen_reg  <= slen_next;
            ovf_reg   <= ovf_next;
            drop_reg  <= drop_next;
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (map_we)
            begin
                map_reg[map_waddr] <= map_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[stg_reg] <= len1;
        end
        phys_reg <= phys_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        os_reg   <= os_next;
        ob_reg   <= ob_next;
        oe_reg   <= oe_next;
        od_reg   <= od_next;
        oq_reg   <= oq_next;
        ot_reg   <= ot_next;
    end
endmodule

@@ dv/tb_frame_ring_queue_with_drop_policy.sv @@
// tb_frame_ring_queue_with_drop_policy: directed table plus random frame traffic,
// every result checked against an in-bench model of the frame ring, typed rows against their table status and count.
// depends on frq_pkg, frq_if and frame_ring_queue_with_drop_policy
module tb_frame_ring_queue_with_drop_policy;
    import frq_pkg::*;

    localparam int NSLOT      = 8;
    localparam int NBYTE      = 64;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        frq_status_t st;
        logic [7:0]  b;
        logic        eor;
        logic        drp;
        logic [3:0]  q;
        logic [31:0] tot;
    } result_t;

    typedef struct {
        bit          is_cfg;
        frq_reg_t    idx;
        logic [6:0]  wval;
        frq_action_t act;
        logic [7:0]  d;
        logic        l;
        logic [6:0]  room;
        bit          typed;
        frq_status_t t_st;
        logic [3:0]  t_q;
    } row_t;

    logic clk;
    logic rst_n;

    frq_req_if req_ch ();
    frq_rsp_if rsp_ch ();
    frq_cfg_if cfg_ch ();

    frame_ring_queue_with_drop_policy dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // model of the ring
    logic [3:0]  depth_reg;
    logic [6:0]  maxlen_reg;
    logic        drop_new_reg;
    logic [7:0]  frame_mem [NSLOT+1][NBYTE];
    int unsigned frame_len [NSLOT+1];
    int unsigned pos_to_slot [NSLOT];
    int unsigned rd_pos, held, stage_slot, stage_len;
    bit          stage_ovf;
    logic [31:0] drops;

    result_t     pending_results [$];
    int          mismatches;
    int          results_seen;
    int          requests_sent;
    int          cfg_writes;
    int          idle_gap_pct;
    int          stall_pct;
    int          hold_cycles;
    int          quiet_cycles;

    always #5 clk = ~clk;

    function automatic void model_reset();
        depth_reg    = 4'd8;
        maxlen_reg   = 7'd64;
        drop_new_reg = 1'b0;
        for (int i = 0; i < NSLOT; i++) pos_to_slot[i] = i;
        for (int i = 0; i <= NSLOT; i++) frame_len[i] = 0;
        rd_pos     = 0;
        held       = 0;
        stage_slot = NSLOT;
        stage_len  = 0;
        stage_ovf  = 0;
        drops      = '0;
    endfunction

    function automatic void add_result(frq_status_t st, logic [7:0] b, logic eor, logic drp);
        result_t r;
        r.st  = st;
        r.b   = b;
        r.eor = eor;
        r.drp = drp;
        r.q   = held[3:0];
        r.tot = drops;
        pending_results.push_back(r);
    endfunction

    function automatic void model_write(frq_reg_t idx, logic [6:0] v);
        case (idx)
            REG_RING_DEPTH:
            begin
                depth_reg = v[3:0];
                held      = 0;
                rd_pos    = 0;
            end
            REG_MAX_FRAME_LEN: maxlen_reg = v;
            REG_DROP_POLICY:   drop_new_reg = v[0];
            default: ;
        endcase
    endfunction

    function automatic void model_request(frq_action_t act, logic [7:0] d, logic l,
                                          logic [6:0] room);
        int unsigned dep, mx, wpos, freed, phys, n;
        bit dr;
        dep = (depth_reg < 1) ? 1 : (depth_reg > NSLOT) ? NSLOT : depth_reg;
        mx  = (maxlen_reg > NBYTE) ? NBYTE : maxlen_reg;
        if (rd_pos >= dep) rd_pos = 0;
        if (held > dep) held = dep;
        dr = 0;
        case (act)
            ACT_PUSH:
            begin
                if (stage_len >= mx)
                    stage_ovf = 1;
                else
                begin
                    frame_mem[stage_slot][stage_len] = d;
                    stage_len++;
                end
                if (l)
                begin
                    if (stage_ovf || stage_len == 0)
                    begin
                        stage_len = 0;
                        stage_ovf = 0;
                        add_result(ST_TOO_LONG, 8'd0, 1'b1, 1'b0);
                    end
                    else if (held >= dep && drop_new_reg)
                    begin
                        if (drops != DROP_MAX) drops++;
                        stage_len = 0;
                        add_result(ST_OK, 8'd0, 1'b1, 1'b1);
                    end
                    else
                    begin
                        if (held >= dep)
                        begin
                            // ring full: free the oldest frame
                            if (drops != DROP_MAX) drops++;
                            dr     = 1;
                            rd_pos = (rd_pos + 1) % dep;
                            held--;
                        end
                        wpos = (rd_pos + held) % dep;
                        frame_len[stage_slot] = stage_len;
                        freed = pos_to_slot[wpos];
                        pos_to_slot[wpos] = stage_slot;
                        stage_slot = freed;
                        held++;
                        stage_len = 0;
                        stage_ovf = 0;
                        add_result(ST_OK, 8'd0, 1'b1, dr);
                    end
                end
            end
            ACT_POP:
            begin
                if (held == 0)
                    add_result(ST_EMPTY, 8'd0, 1'b1, 1'b0);
                else
                begin
                    phys = pos_to_slot[rd_pos];
                    n    = frame_len[phys];
                    if (room < n)
                        add_result(ST_NO_ROOM, 8'd0, 1'b1, 1'b0);
                    else
                    begin
                        rd_pos = (rd_pos + 1) % dep;
                        held--;
                        if (n == 0)
                            add_result(ST_OK, 8'd0, 1'b1, 1'b0);
                        for (int i = 0; i < n; i++)
                            add_result(ST_OK, frame_mem[phys][i], i + 1 == n, 1'b0);
                    end
                end
            end
            ACT_QUERY: add_result(ST_OK, 8'd0, 1'b1, 1'b0);
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d byte %0h", rsp_ch.status,
                             rsp_ch.byte_out);
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp_ch.status !== e.st || rsp_ch.byte_out !== e.b
                    || rsp_ch.end_of_run !== e.eor || rsp_ch.frame_dropped !== e.drp
                    || rsp_ch.frames_queued !== e.q || rsp_ch.dropped_total !== e.tot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp st %0d b %0h eor %0b drp %0b q %0d tot %0d",
                                 e.st, e.b, e.eor, e.drp, e.q, e.tot);
                        $display("          got st %0d b %0h eor %0b drp %0b q %0d tot %0d",
                                 rsp_ch.status, rsp_ch.byte_out, rsp_ch.end_of_run,
                                 rsp_ch.frame_dropped, rsp_ch.frames_queued,
                                 rsp_ch.dropped_total);
                    end
                end
            end
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(frq_action_t act, logic [7:0] d, logic l, logic [6:0] room,
                                bit typed, frq_status_t t_st, logic [3:0] t_q);
        int before_sz;
        while ($urandom_range(99) < idle_gap_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.action   = act;
        req_ch.data     = d;
        req_ch.last     = l;
        req_ch.out_room = room;
        do @(posedge clk); while (!req_ch.ready);
        before_sz = pending_results.size();
        model_request(act, d, l, room);
        if (typed && pending_results.size() > before_sz)
        begin
            pending_results[before_sz].st = t_st;
            pending_results[before_sz].q  = t_q;
        end
        if (act != ACT_NONE) requests_sent++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge clk);
        // a staged byte gives no result, so wait on past the last result as well
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(frq_reg_t idx, logic [6:0] v);
        drain();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = v;
        do @(posedge clk); while (!cfg_ch.ready);
        model_write(idx, v);
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic push_frame(int len);
        for (int i = 0; i < len; i++)
            send_request(ACT_PUSH, 8'($urandom_range(255)), i == len - 1, 7'd0,
                         0, ST_OK, 4'd0);
    endtask

    task automatic random_traffic(int target);
        int stop_at, r, len;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
                if ($urandom_range(9) == 0) len = maxlen_reg + 1;
                if (len > 70) len = 70;
                push_frame(len);
            end
            else if (r < 85)
                send_request(ACT_POP, 8'($urandom), 1'($urandom),
                             ($urandom_range(2) == 0) ? 7'($urandom_range(7))
                                                      : 7'($urandom_range(127)),
                             0, ST_OK, 4'd0);
            else if (r < 93)
                send_request(ACT_QUERY, 8'($urandom), 1'($urandom), 7'($urandom),
                             0, ST_OK, 4'd0);
            else
                send_request(ACT_NONE, 8'($urandom), 1'($urandom), 7'($urandom),
                             0, ST_OK, 4'd0);
        end
    endtask

    row_t directed [] = '{
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b0, 7'd64,  1, ST_EMPTY,    4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_QUERY, 8'h00, 1'b0, 7'd0,   1, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_NONE,  8'hff, 1'b1, 7'd127, 0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h00, 1'b1, 7'd0,   1, ST_OK,       4'd1},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'hff, 1'b0, 7'd0,   0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'ha5, 1'b1, 7'd127, 1, ST_OK,       4'd2},
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b0, 7'd0,   1, ST_NO_ROOM,  4'd2},
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b0, 7'd64,  0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b0, 7'd127, 0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b1, 7'd1,   1, ST_EMPTY,    4'd0},
        '{1, REG_MAX_FRAME_LEN, 7'd2, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        '{1, REG_RING_DEPTH,    7'd1, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        '{1, REG_DROP_POLICY,   7'd1, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        // frame too long, then a full ring drops the incoming frame
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h11, 1'b0, 7'd0,   0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h22, 1'b0, 7'd0,   0, ST_OK,       4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h33, 1'b1, 7'd0,   1, ST_TOO_LONG, 4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h44, 1'b1, 7'd0,   1, ST_OK,       4'd1},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h55, 1'b1, 7'd0,   1, ST_OK,       4'd1},
        '{1, REG_DROP_POLICY,   7'd0, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h66, 1'b1, 7'd0,   1, ST_OK,       4'd1},
        '{0, REG_UNUSED, 7'd0, ACT_POP,   8'h00, 1'b0, 7'd64,  0, ST_OK,       4'd0},
        '{1, REG_MAX_FRAME_LEN, 7'd0, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h77, 1'b1, 7'd0,   1, ST_TOO_LONG, 4'd0},
        '{1, REG_MAX_FRAME_LEN, 7'd127, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK, 4'd0},
        '{1, REG_RING_DEPTH,    7'd0, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0},
        '{0, REG_UNUSED, 7'd0, ACT_PUSH,  8'h88, 1'b1, 7'd0,   1, ST_OK,       4'd1},
        '{1, REG_RING_DEPTH,    7'd15, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,  4'd0},
        '{1, REG_UNUSED,        7'd5, ACT_PUSH, 8'h00, 1'b0, 7'd0, 0, ST_OK,   4'd0}
    };

    initial
    begin
        int send_pct [4] = '{0, 45, 0, 15};
        int recv_pct [4] = '{0, 0, 45, 15};
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_PUSH;
        req_ch.data  = '0;
        req_ch.last  = 1'b0;
        req_ch.out_room = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_RING_DEPTH;
        cfg_ch.wdata = '0;
        mismatches   = 0;
        results_seen = 0;
        requests_sent = 0;
        cfg_writes   = 0;
        idle_gap_pct = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        model_reset();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].idx, directed[i].wval);
            else
                send_request(directed[i].act, directed[i].d, directed[i].l, directed[i].room,
                             directed[i].typed, directed[i].t_st, directed[i].t_q);
        end

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_RING_DEPTH, (p == 0) ? 7'd8 : (p == 1) ? 7'd1 : 7'($urandom_range(1, 8)));
            write_reg(REG_MAX_FRAME_LEN, (p == 2) ? 7'd64 : 7'($urandom_range(1, 10)));
            write_reg(REG_DROP_POLICY, 7'(p % 2));
            idle_gap_pct = send_pct[p];
            stall_pct    = recv_pct[p];
            random_traffic(22);
        end

        // long output stall while requests keep coming, so the input backs up
        drain();
        idle_gap_pct = 0;
        stall_pct    = 0;
        hold_cycles  = 300;
        random_traffic(12);
        drain();

        repeat (20) @(negedge clk);
        $display("covered %0d requests, %0d register writes, %0d results checked",
                 requests_sent, cfg_writes, results_seen);
        $display("four idle/stall mixes, full-ring drops both ways, long output stall");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/frq_pkg.sv
hw/rtl/frq_if.sv
hw/rtl/frq_ram.sv
hw/rtl/frame_ring_queue_with_drop_policy.sv
dv/tb_frame_ring_queue_with_drop_policy.sv
